FILE: rtl/bpfb_pkg.sv
`timescale 1ns / 1ps

package bpfb_pkg;

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_SET_PIXEL = 2'd0,
    OP_CLR_PIXEL = 2'd1,
    OP_READ_BYTE = 2'd2,
    OP_COLUMN    = 2'd3
  } op_t;

  // Plane codes; for a byte read, any code with bit 1 set reads both planes OR-ed
  localparam logic [1:0] PLANE_TEXT = 2'd0;
  localparam logic [1:0] PLANE_GFX  = 2'd1;

  // Offset of the second graphics page
  localparam int PAGE_STRIDE = 'h1600;

  // Register index decoded from the config address
  localparam logic REG_PAGE_SELECT = 1'b0;

  // Pixel mask, leftmost pixel in the MSB
  function automatic logic [7:0] pixel_mask(input logic [2:0] col);
    return 8'h80 >> col;
  endfunction

endpackage

FILE: rtl/bitplane_pixel_frame_buffer_top.sv
`timescale 1ns / 1ps
// Sequence: an accepted transaction runs its memory reads (one for pixel set/clear and one-plane
//   reads, two for a two-plane read, 16 for a printer column byte), merges the registered data,
//   then waits in the done state until the result register is free; one transaction at a time,
//   with the single memory port giving one read per cycle.
// Reset: synchronous, active low; a clearing pass then writes zero to all MEMORY_DEPTH
//   bytes, one per cycle (16384 bytes by default), with in_stall high throughout.
module bitplane_pixel_frame_buffer_top #(
  parameter int BYTES_PER_ROW = 16,
  parameter int GRAPHICS_BASE = 5632,
  parameter int MEMORY_DEPTH  = 16384,
  parameter int ROWS          = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  bpfb_pkg::op_t     in_op,
  input  logic [6:0]        in_x,
  input  logic [5:0]        in_y,
  input  logic [1:0]        in_plane,
  input  logic [9:0]        in_byte_index,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_data,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  import bpfb_pkg::*;

  localparam int AW      = $clog2(MEMORY_DEPTH);
  localparam int RAW_MAX = GRAPHICS_BASE + PAGE_STRIDE + 71 * BYTES_PER_ROW + 16 + 1024;
  localparam int RAW_W   = $clog2(RAW_MAX + 1);
  localparam int SUM_W   = ((RAW_W > AW) ? RAW_W : AW) + 1;
  localparam int WRAP_N  = $clog2(RAW_MAX / MEMORY_DEPTH + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  // Reduce an address modulo the memory depth by binary compare-subtract
  function automatic logic [AW-1:0] wrap_addr(input logic [SUM_W-1:0] a);
    logic [SUM_W-1:0] v;
    v = a;
    for (int i = WRAP_N - 1; i >= 0; i--) begin
      if (v >= (SUM_W'(MEMORY_DEPTH) << i)) begin
        v = v - (SUM_W'(MEMORY_DEPTH) << i);
      end
    end
    return v[AW-1:0];
  endfunction

  state_t           state_r;
  logic [AW-1:0]    clr_r;
  logic             page_r;
  op_t              op_r;
  logic [6:0]       x_r;
  logic [5:0]       y_r;
  logic [1:0]       plane_r;
  logic [9:0]       idx_r;
  logic [4:0]       step_r;
  logic             rd_v_r;
  logic [4:0]       rd_step_r;
  logic [AW-1:0]    rd_addr_r;
  logic [7:0]       acc_r;
  logic [7:0]       res_r;
  logic             out_valid_r;
  logic [7:0]       out_data_r;

  // Display memory, one write and one registered read port
  logic [7:0]       mem [MEMORY_DEPTH];
  logic [7:0]       mem_q_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;

  logic [4:0]       n_reads;
  logic             issue;
  logic             last_data;
  logic             gfx_sel;
  logic [6:0]       row_issue;
  logic [6:0]       row_data;
  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] offset;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       mask;
  logic [7:0]       acc_nxt;
  logic             out_free;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PAGE_SELECT) ? {31'd0, page_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PAGE_SELECT) begin
      page_r <= pwdata[0];
    end
  end

  // Number of memory reads per transaction
  always_comb begin
    case (op_r)
      OP_READ_BYTE: n_reads = plane_r[1] ? 5'd2 : 5'd1;
      OP_COLUMN:    n_reads = 5'd16;
      default:      n_reads = 5'd1;
    endcase
  end

  assign issue     = (state_r == S_RUN) && (step_r < n_reads);
  assign last_data = rd_v_r && (rd_step_r == n_reads - 5'd1);
  assign mask      = pixel_mask(x_r[2:0]);
  assign row_issue = {1'b0, y_r} + {4'd0, step_r[3:1]};
  assign row_data  = {1'b0, y_r} + {4'd0, rd_step_r[3:1]};

  // Read address of the current step
  always_comb begin
    unique case (op_r)
      OP_READ_BYTE: gfx_sel = plane_r[1] ? step_r[0] : (plane_r == PLANE_GFX);
      OP_COLUMN:    gfx_sel = step_r[0];
      default:      gfx_sel = (plane_r == PLANE_GFX);
    endcase
    base = '0;
    if (gfx_sel) begin
      base = SUM_W'(GRAPHICS_BASE) + (page_r ? SUM_W'(PAGE_STRIDE) : '0);
    end
    unique case (op_r)
      OP_READ_BYTE: offset = SUM_W'(idx_r);
      OP_COLUMN:    offset = SUM_W'(row_issue) * SUM_W'(BYTES_PER_ROW) + SUM_W'(x_r[6:3]);
      default:      offset = SUM_W'(y_r) * SUM_W'(BYTES_PER_ROW) + SUM_W'(x_r[6:3]);
    endcase
    rd_addr = wrap_addr(base + offset);
  end

  // Merge the returned byte into the result
  always_comb begin
    acc_nxt = acc_r;
    unique case (op_r)
      OP_SET_PIXEL: acc_nxt = mem_q_r | mask;
      OP_CLR_PIXEL: acc_nxt = mem_q_r & ~mask;
      OP_READ_BYTE: acc_nxt = acc_r | mem_q_r;
      OP_COLUMN: begin
        if (((mem_q_r & mask) != 8'd0) && (SUM_W'(row_data) < SUM_W'(ROWS))) begin
          acc_nxt = acc_r | (8'h80 >> rd_step_r[3:1]);
        end
      end
    endcase
  end

  // Memory port control: clearing pass or pixel write-back
  always_comb begin
    mem_re = issue;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = 8'd0;
    end else begin
      mem_we    = rd_v_r && (op_r == OP_SET_PIXEL || op_r == OP_CLR_PIXEL);
      mem_waddr = rd_addr_r;
      mem_wdata = acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      step_r      <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r <= issue;
      // result valid: load a new one or drop the one just taken
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(MEMORY_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_op;
            x_r     <= in_x;
            y_r     <= in_y;
            plane_r <= in_plane;
            idx_r   <= in_byte_index;
            step_r  <= '0;
            acc_r   <= 8'd0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (issue) begin
            step_r    <= step_r + 5'd1;
            rd_step_r <= step_r;
            rd_addr_r <= rd_addr;
          end
          if (rd_v_r) begin
            acc_r <= acc_nxt;
          end
          if (last_data) begin
            res_r   <= acc_nxt;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");

  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_RUN && step_r == 5'd0))
    else $error("accepted transaction did not start a run");

  a_write_only_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != S_CLEAR) |-> (op_r == OP_SET_PIXEL || op_r == OP_CLR_PIXEL))
    else $error("memory write from a read-only operation");

  a_data_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (state_r == S_RUN))
    else $error("read data returned outside a run");

endmodule
